// ===== rtl/rtd_pkg.sv =====
// Shared types, constants and the rounding helper for the lens distortion pipeline.
// No dependencies; every other file of the block imports this package.
package rtd_pkg;

	localparam int FRAC_BITS  = 20;
	localparam int PIPE_DEPTH = 15;

	typedef logic signed [23:0] coord_t;
	typedef logic signed [23:0] coef_t;
	typedef logic        [23:0] ufix_t;
	typedef logic signed [31:0] pix_t;
	typedef logic        [2:0]  cfg_index_t;
	typedef logic        [23:0] cfg_data_t;

	typedef enum logic [2:0] {
		CFG_K1 = 3'd0,
		CFG_K2 = 3'd1,
		CFG_P1 = 3'd2,
		CFG_P2 = 3'd3,
		CFG_FX = 3'd4,
		CFG_FY = 3'd5,
		CFG_CX = 3'd6,
		CFG_CY = 3'd7
	} cfg_reg_t;

	localparam ufix_t FOCAL_RESET = 24'd1024;
	localparam pix_t  PIX_MAX     = 32'sh7FFF_FFFF;
	localparam pix_t  PIX_MIN     = -32'sh7FFF_FFFF - 32'sd1;

	// Divides by 2^20 and rounds to nearest, ties away from zero.
	function automatic logic signed [63:0] rnd20(input logic signed [63:0] v);
		logic signed [63:0] t;
		t = v + 64'sd524288 - 64'(v[63]);
		return t >>> FRAC_BITS;
	endfunction

endpackage

// ===== rtl/rtd_in_if.sv =====
// Input channel carrying one normalized point per transaction.
// Depends on rtd_pkg for the coordinate type.
interface rtd_in_if;
	import rtd_pkg::*;

	logic   valid;
	logic   ready;
	coord_t x_norm;
	coord_t y_norm;

	modport source (output valid, x_norm, y_norm, input ready);
	modport sink   (input valid, x_norm, y_norm, output ready);
endinterface

// ===== rtl/rtd_out_if.sv =====
// Output channel carrying one projected pixel per transaction.
// Depends on rtd_pkg for the pixel type.
interface rtd_out_if;
	import rtd_pkg::*;

	logic valid;
	logic ready;
	pix_t pixel_u;
	pix_t pixel_v;
	logic saturated;

	modport source (output valid, pixel_u, pixel_v, saturated, input ready);
	modport sink   (input valid, pixel_u, pixel_v, saturated, output ready);
endinterface

// ===== rtl/radial_tangential_distort_project.sv =====
// Throughput: one transaction per cycle while the output is not stalled, set by the fifteen-stage multiply pipeline.
// Each stage holds while the stage after it is full and stalled, so bubbles are filled.
// Reset clears the stage valid bits and loads the register reset values; data is not reset.
// Depends on rtd_pkg, rtd_in_if and rtd_out_if.
module radial_tangential_distort_project (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  rtd_pkg::cfg_index_t cfg_index,
	input  rtd_pkg::cfg_data_t  cfg_data,
	rtd_in_if.sink              points,
	rtd_out_if.source           pixels
);
	import rtd_pkg::*;

	localparam logic signed [50:0] R_MAX = 51'(PIX_MAX);
	localparam logic signed [50:0] R_MIN = 51'(PIX_MIN);

	coef_t k1_q, k2_q, p1_q, p2_q;
	ufix_t fx_q, fy_q, cx_q, cy_q;

	logic [PIPE_DEPTH:1] valid_q;
	logic [PIPE_DEPTH:1] adv;

	// Stage 1
	coord_t x_s1, y_s1;
	logic signed [47:0] xsq_s1, ysq_s1, xyp_s1;
	// Stage 2
	coord_t x_s2, y_s2;
	logic signed [27:0] xx_s2, yy_s2, xy_s2;
	logic signed [28:0] r2_s2;
	// Stage 3
	coord_t x_s3, y_s3;
	logic signed [57:0] r2sq_s3;
	logic signed [52:0] k1r2_s3;
	logic signed [51:0] pa_s3, pb_s3;
	logic signed [29:0] sx_s3, sy_s3;
	// Stage 4
	coord_t x_s4, y_s4;
	logic signed [35:0] r4_s4;
	logic signed [52:0] k1r2_s4;
	logic signed [51:0] pa_s4, pb_s4;
	logic signed [53:0] tp1_s4, tp2_s4;
	// Stage 5
	coord_t x_s5, y_s5;
	logic signed [52:0] k1r2_s5;
	logic signed [39:0] k2h_s5;
	logic signed [44:0] k2l_s5;
	logic signed [33:0] tx_s5, ty_s5;
	// Stage 6
	coord_t x_s6, y_s6;
	logic signed [52:0] k1r2_s6;
	logic signed [58:0] k2r4_s6;
	logic signed [33:0] tx_s6, ty_s6;
	// Stage 7
	coord_t x_s7, y_s7;
	logic signed [40:0] rad_s7;
	logic signed [33:0] tx_s7, ty_s7;
	// Stage 8
	logic signed [44:0] hx_s8, lx_s8, hy_s8, ly_s8;
	logic signed [33:0] tx_s8, ty_s8;
	// Stage 9
	logic signed [63:0] px_s9, py_s9;
	logic signed [33:0] tx_s9, ty_s9;
	// Stage 10
	logic signed [43:0] dx_s10, dy_s10;
	// Stage 11
	logic [43:0] magx_s11, magy_s11;
	logic        negx_s11, negy_s11;
	// Stage 12
	logic [47:0] hfx_s12, hfy_s12;
	logic [43:0] lfx_s12, lfy_s12;
	logic        negx_s12, negy_s12;
	// Stage 13
	logic [48:0] qx_s13, qy_s13;
	logic        negx_s13, negy_s13;
	// Stage 14
	logic signed [50:0] ru_s14, rv_s14;
	// Stage 15
	pix_t u_s15, v_s15;
	logic sat_s15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k1_q <= '0;
			k2_q <= '0;
			p1_q <= '0;
			p2_q <= '0;
			fx_q <= FOCAL_RESET;
			fy_q <= FOCAL_RESET;
			cx_q <= '0;
			cy_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				CFG_K1: k1_q <= coef_t'(cfg_data);
				CFG_K2: k2_q <= coef_t'(cfg_data);
				CFG_P1: p1_q <= coef_t'(cfg_data);
				CFG_P2: p2_q <= coef_t'(cfg_data);
				CFG_FX: fx_q <= cfg_data;
				CFG_FY: fy_q <= cfg_data;
				CFG_CX: cx_q <= cfg_data;
				CFG_CY: cy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		adv[PIPE_DEPTH] = !valid_q[PIPE_DEPTH] || pixels.ready;
		for (int k = PIPE_DEPTH - 1; k >= 1; k--) begin
			adv[k] = !valid_q[k] || adv[k + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (adv[1]) begin
				valid_q[1] <= points.valid;
			end
			for (int k = 2; k <= PIPE_DEPTH; k++) begin
				if (adv[k]) begin
					valid_q[k] <= valid_q[k - 1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			x_s1   <= points.x_norm;
			y_s1   <= points.y_norm;
			xsq_s1 <= points.x_norm * points.x_norm;
			ysq_s1 <= points.y_norm * points.y_norm;
			xyp_s1 <= points.x_norm * points.y_norm;
		end
		if (adv[2]) begin
			x_s2  <= x_s1;
			y_s2  <= y_s1;
			xx_s2 <= 28'(rnd20(64'(xsq_s1)));
			yy_s2 <= 28'(rnd20(64'(ysq_s1)));
			xy_s2 <= 28'(rnd20(64'(xyp_s1)));
			r2_s2 <= 29'(rnd20(64'(xsq_s1) + 64'(ysq_s1)));
		end
		if (adv[3]) begin
			x_s3    <= x_s2;
			y_s3    <= y_s2;
			r2sq_s3 <= r2_s2 * r2_s2;
			k1r2_s3 <= k1_q * r2_s2;
			pa_s3   <= p1_q * xy_s2;
			pb_s3   <= p2_q * xy_s2;
			sx_s3   <= 30'(r2_s2) + (30'(xx_s2) <<< 1);
			sy_s3   <= 30'(r2_s2) + (30'(yy_s2) <<< 1);
		end
		if (adv[4]) begin
			x_s4    <= x_s3;
			y_s4    <= y_s3;
			r4_s4   <= 36'(rnd20(64'(r2sq_s3)));
			k1r2_s4 <= k1r2_s3;
			pa_s4   <= pa_s3;
			pb_s4   <= pb_s3;
			tp2_s4  <= p2_q * sx_s3;
			tp1_s4  <= p1_q * sy_s3;
		end
		if (adv[5]) begin
			x_s5    <= x_s4;
			y_s5    <= y_s4;
			k1r2_s5 <= k1r2_s4;
			k2h_s5  <= k2_q * $signed(r4_s4[35:20]);
			k2l_s5  <= k2_q * $signed({1'b0, r4_s4[19:0]});
			tx_s5   <= 34'(rnd20((64'(pa_s4) <<< 1) + 64'(tp2_s4)));
			ty_s5   <= 34'(rnd20(64'(tp1_s4) + (64'(pb_s4) <<< 1)));
		end
		if (adv[6]) begin
			x_s6    <= x_s5;
			y_s6    <= y_s5;
			k1r2_s6 <= k1r2_s5;
			k2r4_s6 <= 59'((64'(k2h_s5) <<< 20) + 64'(k2l_s5));
			tx_s6   <= tx_s5;
			ty_s6   <= ty_s5;
		end
		if (adv[7]) begin
			x_s7   <= x_s6;
			y_s7   <= y_s6;
			rad_s7 <= 41'(64'sd1048576 + rnd20(64'(k1r2_s6) + 64'(k2r4_s6)));
			tx_s7  <= tx_s6;
			ty_s7  <= ty_s6;
		end
		if (adv[8]) begin
			hx_s8 <= x_s7 * $signed(rad_s7[40:20]);
			lx_s8 <= x_s7 * $signed({1'b0, rad_s7[19:0]});
			hy_s8 <= y_s7 * $signed(rad_s7[40:20]);
			ly_s8 <= y_s7 * $signed({1'b0, rad_s7[19:0]});
			tx_s8 <= tx_s7;
			ty_s8 <= ty_s7;
		end
		if (adv[9]) begin
			px_s9 <= (64'(hx_s8) <<< 20) + 64'(lx_s8);
			py_s9 <= (64'(hy_s8) <<< 20) + 64'(ly_s8);
			tx_s9 <= tx_s8;
			ty_s9 <= ty_s8;
		end
		if (adv[10]) begin
			dx_s10 <= 44'(rnd20(px_s9)) + 44'(tx_s9);
			dy_s10 <= 44'(rnd20(py_s9)) + 44'(ty_s9);
		end
		if (adv[11]) begin
			negx_s11 <= dx_s10[43];
			negy_s11 <= dy_s10[43];
			magx_s11 <= dx_s10[43] ? 44'(-dx_s10) : 44'(dx_s10);
			magy_s11 <= dy_s10[43] ? 44'(-dy_s10) : 44'(dy_s10);
		end
		if (adv[12]) begin
			hfx_s12  <= magx_s11[43:20] * fx_q;
			lfx_s12  <= magx_s11[19:0] * fx_q;
			hfy_s12  <= magy_s11[43:20] * fy_q;
			lfy_s12  <= magy_s11[19:0] * fy_q;
			negx_s12 <= negx_s11;
			negy_s12 <= negy_s11;
		end
		if (adv[13]) begin
			qx_s13   <= 49'(hfx_s12) + 49'((lfx_s12 + 44'h8_0000) >> FRAC_BITS);
			qy_s13   <= 49'(hfy_s12) + 49'((lfy_s12 + 44'h8_0000) >> FRAC_BITS);
			negx_s13 <= negx_s12;
			negy_s13 <= negy_s12;
		end
		if (adv[14]) begin
			ru_s14 <= (negx_s13 ? -$signed({2'b00, qx_s13}) : $signed({2'b00, qx_s13}))
				+ $signed({27'd0, cx_q});
			rv_s14 <= (negy_s13 ? -$signed({2'b00, qy_s13}) : $signed({2'b00, qy_s13}))
				+ $signed({27'd0, cy_q});
		end
		if (adv[15]) begin
			u_s15   <= (ru_s14 > R_MAX) ? PIX_MAX : (ru_s14 < R_MIN) ? PIX_MIN : ru_s14[31:0];
			v_s15   <= (rv_s14 > R_MAX) ? PIX_MAX : (rv_s14 < R_MIN) ? PIX_MIN : rv_s14[31:0];
			sat_s15 <= (ru_s14 > R_MAX) || (ru_s14 < R_MIN)
				|| (rv_s14 > R_MAX) || (rv_s14 < R_MIN);
		end
	end

	assign points.ready     = adv[1];
	assign pixels.valid     = valid_q[PIPE_DEPTH];
	assign pixels.pixel_u   = u_s15;
	assign pixels.pixel_v   = v_s15;
	assign pixels.saturated = sat_s15;

endmodule

// ===== rtl/rtd_checker.sv =====
// Port-level checker for the lens distortion block, with its bind statement.
// Depends on rtd_pkg and on the port names of radial_tangential_distort_project.
module rtd_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input rtd_pkg::pix_t pixel_u,
	input rtd_pkg::pix_t pixel_v,
	input logic          saturated
);
	import rtd_pkg::*;

	localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             in_acc;
	logic             out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CNT_W'(in_acc) - CNT_W'(out_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_u) && $stable(pixel_v)
			&& $stable(saturated))
		else $error("Stalled output transaction changed.");

	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("Input refused although the output was not stalled.");

	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q <= CNT_W'(PIPE_DEPTH)) && (!out_valid || cnt_q != '0))
		else $error("Transactions in flight out of range or output without input.");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> pixel_u == PIX_MAX || pixel_u == PIX_MIN
			|| pixel_v == PIX_MAX || pixel_v == PIX_MIN)
		else $error("Saturation flagged without a clipped coordinate.");

endmodule

bind radial_tangential_distort_project rtd_checker u_rtd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (points.valid),
	.in_ready  (points.ready),
	.out_valid (pixels.valid),
	.out_ready (pixels.ready),
	.pixel_u   (pixels.pixel_u),
	.pixel_v   (pixels.pixel_v),
	.saturated (pixels.saturated)
);

// ===== tb/radial_tangential_distort_project_test.sv =====
`timescale 1ns / 1ps
// Testbench for radial_tangential_distort_project: lens distortion and pixel projection.
// A driver feeds points in random bursts, a monitor checks every pixel against a local predictor.
// Depends on rtd_pkg, rtd_in_if, rtd_out_if and the block itself.
module radial_tangential_distort_project_test;
	import rtd_pkg::*;

	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} norm_point_t;

	typedef struct packed {
		pix_t u;
		pix_t v;
		logic saturated;
	} pixel_result_t;

	localparam wide_t  ONE_Q20    = wide_t'(1) <<< FRAC_BITS;
	localparam wide_t  ROUND_HALF = wide_t'(1) <<< (FRAC_BITS - 1);
	localparam coord_t COORD_MAX  = 24'sh7FFFFF;
	localparam coord_t COORD_MIN  = 24'sh800000;
	localparam ufix_t  UFIX_MAX   = 24'hFFFFFF;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wr_en;
	cfg_index_t cfg_index;
	cfg_data_t  cfg_data;

	rtd_in_if  points();
	rtd_out_if pixels();

	radial_tangential_distort_project DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.points    (points),
		.pixels    (pixels)
	);

	coef_t k1_setting = '0;
	coef_t k2_setting = '0;
	coef_t p1_setting = '0;
	coef_t p2_setting = '0;
	ufix_t focal_x_setting = FOCAL_RESET;
	ufix_t focal_y_setting = FOCAL_RESET;
	ufix_t center_x_setting = '0;
	ufix_t center_y_setting = '0;

	norm_point_t   pending_points[$];
	pixel_result_t expected_pixels[$];
	norm_point_t   next_point;
	pixel_result_t wanted_pixel;
	int unsigned   gap_left;
	int unsigned   burst_left;
	logic [15:0]   stall_pattern;
	logic [3:0]    pattern_pos;
	int unsigned   mismatch_count = 0;

	always #4 clk = ~clk;

	function automatic wide_t round_q20(input wide_t value);
		wide_t magnitude;
		magnitude = (value < 0) ? -value : value;
		magnitude = (magnitude + ROUND_HALF) >>> FRAC_BITS;
		return (value < 0) ? -magnitude : magnitude;
	endfunction

	function automatic pix_t project_axis(input wide_t offset, input ufix_t focal,
			input ufix_t center, inout logic clipped);
		wide_t f;
		wide_t c;
		wide_t r;
		f = focal;
		c = center;
		r = round_q20(offset * f) + c;
		if (r > PIX_MAX) begin
			clipped = 1'b1;
			return PIX_MAX;
		end
		if (r < PIX_MIN) begin
			clipped = 1'b1;
			return PIX_MIN;
		end
		return pix_t'(r);
	endfunction

	function automatic pixel_result_t project_point(input coord_t x_in, input coord_t y_in);
		wide_t x, y, xx, yy, xy, r2, r4, radial, tan_x, tan_y;
		wide_t k1, k2, p1, p2;
		pixel_result_t result;
		logic clipped;
		x = x_in;
		y = y_in;
		k1 = k1_setting;
		k2 = k2_setting;
		p1 = p1_setting;
		p2 = p2_setting;
		xx = round_q20(x * x);
		yy = round_q20(y * y);
		xy = round_q20(x * y);
		r2 = round_q20(x * x + y * y);
		r4 = round_q20(r2 * r2);
		radial = ONE_Q20 + round_q20(k1 * r2 + k2 * r4);
		tan_x = round_q20(2 * p1 * xy + p2 * (r2 + 2 * xx));
		tan_y = round_q20(p1 * (r2 + 2 * yy) + 2 * p2 * xy);
		clipped = 1'b0;
		result.u = project_axis(round_q20(radial * x) + tan_x, focal_x_setting,
			center_x_setting, clipped);
		result.v = project_axis(round_q20(radial * y) + tan_y, focal_y_setting,
			center_y_setting, clipped);
		result.saturated = clipped;
		return result;
	endfunction

	function automatic cfg_data_t random_coef();
		case ($urandom_range(0, 4))
			0: return cfg_data_t'(COORD_MAX);
			1: return cfg_data_t'(COORD_MIN);
			2: return cfg_data_t'($urandom_range(0, 'h3FFFF) - 'h1FFFF);
			default: return cfg_data_t'($urandom);
		endcase
	endfunction

	function automatic cfg_data_t random_ufix();
		case ($urandom_range(0, 4))
			0: return UFIX_MAX;
			1: return '0;
			2: return cfg_data_t'($urandom_range(100 * 1024, 1000 * 1024));
			default: return cfg_data_t'($urandom);
		endcase
	endfunction

	function automatic coord_t random_coord();
		case ($urandom_range(0, 9))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2, 3, 4: return coord_t'($urandom_range(0, 'h200000) - 'h100000);
			default: return coord_t'($urandom);
		endcase
	endfunction

	task automatic write_register(input cfg_reg_t index, input cfg_data_t value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		case (index)
			CFG_K1: k1_setting = value;
			CFG_K2: k2_setting = value;
			CFG_P1: p1_setting = value;
			CFG_P2: p2_setting = value;
			CFG_FX: focal_x_setting = value;
			CFG_FY: focal_y_setting = value;
			CFG_CX: center_x_setting = value;
			CFG_CY: center_y_setting = value;
			default: ;
		endcase
	endtask

	task automatic load_lens(input cfg_data_t k1, input cfg_data_t k2, input cfg_data_t p1,
			input cfg_data_t p2, input cfg_data_t fx, input cfg_data_t fy,
			input cfg_data_t cx, input cfg_data_t cy);
		write_register(CFG_K1, k1);
		write_register(CFG_K2, k2);
		write_register(CFG_P1, p1);
		write_register(CFG_P2, p2);
		write_register(CFG_FX, fx);
		write_register(CFG_FY, fy);
		write_register(CFG_CX, cx);
		write_register(CFG_CY, cy);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic queue_point(input coord_t x, input coord_t y);
		pending_points.push_back('{x: x, y: y});
	endtask

	task automatic wait_for_idle();
		do
			@(negedge clk);
		while (pending_points.size() != 0 || points.valid || expected_pixels.size() != 0);
	endtask

	task automatic note_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s", $time, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points.valid <= 1'b0;
			points.x_norm <= '0;
			points.y_norm <= '0;
			gap_left <= 0;
			burst_left <= 1;
		end else begin
			if (points.valid && points.ready)
				expected_pixels.push_back(project_point(points.x_norm, points.y_norm));
			if (!points.valid || points.ready) begin
				if (gap_left != 0 || pending_points.size() == 0) begin
					points.valid <= 1'b0;
					if (gap_left != 0)
						gap_left <= gap_left - 1;
				end else begin
					next_point = pending_points.pop_front();
					points.x_norm <= next_point.x;
					points.y_norm <= next_point.y;
					points.valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left <= burst_left - 1;
					end else begin
						burst_left <= $urandom_range(1, 24);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixels.ready <= 1'b0;
			stall_pattern <= 16'hFFFF;
			pattern_pos <= '0;
		end else begin
			if (pixels.valid && pixels.ready) begin
				if (expected_pixels.size() == 0) begin
					note_mismatch($sformatf("unexpected transaction: u=%0d v=%0d saturated=%0b",
						pixels.pixel_u, pixels.pixel_v, pixels.saturated));
				end else begin
					wanted_pixel = expected_pixels.pop_front();
					if (pixels.pixel_u !== wanted_pixel.u || pixels.pixel_v !== wanted_pixel.v
							|| pixels.saturated !== wanted_pixel.saturated)
						note_mismatch($sformatf({"pixel mismatch: expected u=%0d v=%0d ",
							"saturated=%0b, got u=%0d v=%0d saturated=%0b"},
							wanted_pixel.u, wanted_pixel.v, wanted_pixel.saturated,
							pixels.pixel_u, pixels.pixel_v, pixels.saturated));
				end
			end
			pixels.ready <= stall_pattern[pattern_pos];
			pattern_pos <= pattern_pos + 1'b1;
			if (pattern_pos == 4'd15)
				stall_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_K1;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: focal length 1024, no distortion.
		queue_point('0, '0);
		queue_point(COORD_MAX, COORD_MAX);
		queue_point(COORD_MIN, COORD_MIN);
		queue_point(COORD_MAX, COORD_MIN);
		queue_point(COORD_MIN, '0);
		queue_point(24'sd1, -24'sd1);
		queue_point(24'sh100000, 24'sh100000);
		queue_point(-24'sh080000, COORD_MAX);
		wait_for_idle();

		// Largest coefficients and projection drive the outputs into saturation.
		load_lens(cfg_data_t'(COORD_MAX), cfg_data_t'(COORD_MAX), cfg_data_t'(COORD_MAX),
			cfg_data_t'(COORD_MAX), UFIX_MAX, UFIX_MAX, UFIX_MAX, UFIX_MAX);
		queue_point('0, '0);
		queue_point(COORD_MAX, COORD_MAX);
		queue_point(COORD_MIN, COORD_MIN);
		queue_point(COORD_MAX, COORD_MIN);
		queue_point(COORD_MIN, COORD_MAX);
		queue_point(24'sd1, -24'sd1);
		wait_for_idle();

		// Most negative coefficients, zero vertical focal length.
		load_lens(cfg_data_t'(COORD_MIN), cfg_data_t'(COORD_MIN), cfg_data_t'(COORD_MIN),
			cfg_data_t'(COORD_MIN), UFIX_MAX, '0, '0, UFIX_MAX);
		queue_point('0, '0);
		queue_point(COORD_MAX, COORD_MAX);
		queue_point(COORD_MIN, COORD_MIN);
		queue_point(COORD_MAX, COORD_MIN);
		queue_point(COORD_MIN, COORD_MAX);
		queue_point(24'sd1, -24'sd1);
		wait_for_idle();

		for (int phase = 0; phase < 6; phase++) begin
			load_lens(random_coef(), random_coef(), random_coef(), random_coef(),
				random_ufix(), random_ufix(), random_ufix(), random_ufix());
			for (int n = 0; n < 75; n++) begin
				if (phase == 2 && n == 40)
					wait_for_idle();
				queue_point(random_coord(), random_coord());
			end
			wait_for_idle();
		end

		repeat (2 * PIPE_DEPTH) @(posedge clk);
		if (mismatch_count == 0 && expected_pixels.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
